[rtl/gld_pkg.sv]
// Package with shared types and constants for the greedy label declutter block.
package gld_pkg;

    localparam int MaxItemsDefault  = 64;
    localparam int MaxGroupsDefault = 256;
    localparam int CoordBitsDefault = 16;

    typedef struct packed {
        logic signed [15:0] anchor_x;
        logic signed [15:0] anchor_y;
        logic signed [15:0] rel_xmin;
        logic signed [15:0] rel_xmax;
        logic signed [15:0] rel_ymin;
        logic signed [15:0] rel_ymax;
        logic [7:0]         group_id;
        logic               last_item;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         item_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               none_kept;
        logic               overflowed;
        logic               last_result;
    } t_out_item;

endpackage

[rtl/gld_ram.sv]
// Generic single-port-write RAM with one registered read port.
module gld_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/gld_cmp.sv]
// Shared box overlap test unit: compares the current box with one stored box.
module gld_cmp #(
    parameter int CoordBits = 16
) (
    input  logic [4*CoordBits-1:0] i_cur,
    input  logic [4*CoordBits-1:0] i_old,
    output logic                   o_overlap
);
    logic signed [CoordBits-1:0] c_x0, c_x1, c_y0, c_y1;
    logic signed [CoordBits-1:0] o_x0, o_x1, o_y0, o_y1;

    assign {c_x0, c_x1, c_y0, c_y1} = i_cur;
    assign {o_x0, o_x1, o_y0, o_y1} = i_old;
    assign o_overlap = !((c_x0 > o_x1) || (c_x1 < o_x0) || (c_y0 > o_y1) || (c_y1 < o_y0));
endmodule

[rtl/greedy_label_declutter.sv]
// Top level of the greedy label declutter block.
// One item is taken per start while busy is low, and the receiver cannot stall results. After
// the accepting edge the block stays busy in S_GWAIT to read the group's culled flag and in
// S_CHK to test it. It then scans the accepted boxes one per cycle through the box memory
// and the shared compare unit, and ends with a write in S_DONE. An overlap with a box of
// another group stops the scan early, and an item whose group is already culled skips the
// scan and the write. A dropped item leaves busy low unless it is a last item. A last item
// then runs an output pass over the accepted entries. Each kept item's result is held back
// until the next kept one is found, so that the final result carries last_result. A clearing
// pass over all MAX_GROUPS culled-group flags follows before the next frame, and the same
// pass runs after reset. Results appear for exactly one cycle under o_valid.
module greedy_label_declutter #(
    parameter int MAX_ITEMS  = gld_pkg::MaxItemsDefault,
    parameter int MAX_GROUPS = gld_pkg::MaxGroupsDefault,
    parameter int COORD_BITS = gld_pkg::CoordBitsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  gld_pkg::t_in_item   i_item,
    output logic                o_valid,
    output gld_pkg::t_out_item  o_item
);
    import gld_pkg::*;

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = IW + 1;
    localparam int GW = $clog2(MAX_GROUPS);
    localparam int BW = 4 * COORD_BITS;
    localparam int FW = 6 + 16 + 16 + GW;
    localparam int CoordHi  = (1 << (COORD_BITS - 1)) - 1;
    localparam int CoordLo  = -CoordHi - 1;
    localparam int GrpRecip = (65536 + MAX_GROUPS - 1) / MAX_GROUPS;

    typedef enum logic [2:0] {
        S_IDLE, S_GWAIT, S_CHK, S_SCAN, S_DONE, S_OUT, S_OUTW, S_CLR
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_cnt, r_items, r_j;
    logic               r_ovf, r_last, r_hit, r_rv;
    logic [BW-1:0]      r_box;
    logic [GW-1:0]      r_grp, r_gaddr;
    logic [15:0]        r_ax, r_ay;
    logic [5:0]         r_idx;
    logic               r_any;
    logic               r_gwe, r_gwd;
    t_out_item          r_pend;

    logic [BW-1:0]      box_rd;
    logic [FW-1:0]      info_rd;
    logic               culled_rd;
    logic               overlap;
    logic [IW-1:0]      raddr;
    logic               box_we;

    // Saturating add of anchor and relative edge to COORD_BITS.
    function automatic logic [COORD_BITS-1:0] sat_add(logic signed [15:0] a,
                                                      logic signed [15:0] b);
        int s;
        s = int'(a) + int'(b);
        if (s > CoordHi) s = CoordHi;
        else if (s < CoordLo) s = CoordLo;
        return COORD_BITS'(s);
    endfunction

    // Group id modulo MAX_GROUPS by reciprocal multiplication; exact for 8-bit ids.
    function automatic logic [GW-1:0] grp_mod(logic [7:0] g);
        logic [31:0] q;
        logic [31:0] r;
        q = (32'(g) * 32'(GrpRecip)) >> 16;
        r = 32'(g) - q * 32'(MAX_GROUPS);
        return GW'(r);
    endfunction

    assign raddr  = r_j[IW-1:0];
    assign box_we = (r_state == S_DONE) && !r_hit && (r_cnt < CW'(MAX_ITEMS));

    gld_ram #(.Width(BW), .Depth(MAX_ITEMS)) u_box (
        .i_clk(i_clk), .i_we(box_we), .i_waddr(r_cnt[IW-1:0]), .i_wdata(r_box),
        .i_raddr(raddr), .o_rdata(box_rd));

    gld_ram #(.Width(FW), .Depth(MAX_ITEMS)) u_info (
        .i_clk(i_clk), .i_we(box_we), .i_waddr(r_cnt[IW-1:0]),
        .i_wdata({r_idx, r_ax, r_ay, r_grp}), .i_raddr(raddr), .o_rdata(info_rd));

    gld_ram #(.Width(1), .Depth(MAX_GROUPS)) u_cull (
        .i_clk(i_clk), .i_we(r_gwe), .i_waddr(r_gaddr), .i_wdata(r_gwd),
        .i_raddr(r_gaddr), .o_rdata(culled_rd));

    gld_cmp #(.CoordBits(COORD_BITS)) u_cmp (
        .i_cur(r_box), .i_old(box_rd), .o_overlap(overlap));

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_items <= '0;
            r_ovf   <= 1'b0;
            r_gaddr <= '0;
            r_gwe   <= 1'b1;
            r_gwd   <= 1'b0;
            o_valid <= 1'b0;
            r_j     <= '0;
        end else begin
            o_valid <= 1'b0;
            r_gwe   <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_last  <= i_item.last_item;
                        r_ax    <= i_item.anchor_x;
                        r_ay    <= i_item.anchor_y;
                        r_grp   <= grp_mod(i_item.group_id);
                        r_gaddr <= grp_mod(i_item.group_id);
                        r_box   <= {sat_add(i_item.anchor_x, i_item.rel_xmin),
                                    sat_add(i_item.anchor_x, i_item.rel_xmax),
                                    sat_add(i_item.anchor_y, i_item.rel_ymin),
                                    sat_add(i_item.anchor_y, i_item.rel_ymax)};
                        r_idx   <= 6'(r_items);
                        r_hit   <= 1'b0;
                        r_j     <= '0;
                        r_rv    <= 1'b0;
                        if (r_items >= CW'(MAX_ITEMS)) begin
                            r_ovf   <= 1'b1;
                            r_state <= i_item.last_item ? S_OUT : S_IDLE;
                            r_any   <= 1'b0;
                        end else begin
                            r_items <= r_items + 1'b1;
                            r_state <= S_GWAIT;
                        end
                    end
                end
                S_GWAIT: begin
                    // The flag memory reads this group's address at this edge.
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    // Culled flag of this group is now valid.
                    if (culled_rd) begin
                        r_state <= r_last ? S_OUT : S_IDLE;
                        r_any   <= 1'b0;
                        r_j     <= '0;
                    end else begin
                        r_state <= S_SCAN;
                        if (r_cnt != '0) begin
                            r_j <= CW'(1);
                            r_rv <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    // r_rv marks that box_rd holds entry r_j - 1.
                    if (r_rv && overlap && info_rd[GW-1:0] != r_grp) begin
                        r_hit <= 1'b1;
                        r_rv  <= 1'b0;
                        r_state <= S_DONE;
                    end else if (r_j >= r_cnt) begin
                        r_rv <= 1'b0;
                        if (!r_rv) r_state <= S_DONE;
                    end else begin
                        r_j  <= r_j + 1'b1;
                    end
                end
                S_DONE: begin
                    if (r_hit) begin
                        r_gwe <= 1'b1;
                        r_gwd <= 1'b1;
                    end else if (r_cnt < CW'(MAX_ITEMS)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_j     <= '0;
                    r_any   <= 1'b0;
                    r_state <= r_last ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    // Present address r_j to the info memory.
                    if (r_j >= r_cnt) begin
                        // The held result, if any, is the final one of the frame.
                        o_valid <= 1'b1;
                        if (!r_any) begin
                            o_item  <= '{item_index: '0, pos_x: '0, pos_y: '0,
                                         none_kept: 1'b1, overflowed: r_ovf,
                                         last_result: 1'b1};
                        end else begin
                            o_item  <= '{item_index: r_pend.item_index,
                                         pos_x: r_pend.pos_x, pos_y: r_pend.pos_y,
                                         none_kept: 1'b0, overflowed: r_ovf,
                                         last_result: 1'b1};
                        end
                        r_gaddr <= '0;
                        r_gwe   <= 1'b1;
                        r_gwd   <= 1'b0;
                        r_state <= S_CLR;
                    end else begin
                        r_state <= S_OUTW;
                    end
                end
                S_OUTW: begin
                    // Info read is valid; fetch its group flag. The flag is used only after
                    // the address has been held through one read.
                    r_gaddr <= info_rd[GW-1:0];
                    if (r_gaddr == info_rd[GW-1:0] && r_rv) begin
                        if (!culled_rd) begin
                            if (r_any) begin
                                o_valid <= 1'b1;
                                o_item  <= r_pend;
                            end
                            r_pend <= '{item_index: info_rd[FW-1 -: 6],
                                        pos_x: info_rd[GW+31:GW+16],
                                        pos_y: info_rd[GW+15:GW],
                                        none_kept: 1'b0, overflowed: r_ovf,
                                        last_result: 1'b0};
                            r_any <= 1'b1;
                        end
                        r_j     <= r_j + 1'b1;
                        r_rv    <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_rv <= (r_gaddr == info_rd[GW-1:0]);
                    end
                end
                S_CLR: begin
                    if (r_gaddr == GW'(MAX_GROUPS - 1)) begin
                        r_state <= S_IDLE;
                        r_cnt   <= '0;
                        r_items <= '0;
                        r_ovf   <= 1'b0;
                    end else begin
                        r_gaddr <= r_gaddr + 1'b1;
                        r_gwe   <= 1'b1;
                        r_gwd   <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
